// ----- src/qpt_pkg.sv -----
package qpt_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int POS_WIDTH_DEF = 32;

  // product slots of the first stage
  localparam int NUM_PROD = 10;
  localparam int P_WW = 0;
  localparam int P_XX = 1;
  localparam int P_YY = 2;
  localparam int P_ZZ = 3;
  localparam int P_XY = 4;
  localparam int P_WZ = 5;
  localparam int P_XZ = 6;
  localparam int P_WY = 7;
  localparam int P_YZ = 8;
  localparam int P_WX = 9;

  // matrix entries, row major
  localparam int NUM_ENT = 9;

  typedef struct packed {
    logic [NUM_ENT-1:0] neg;
    logic               zero;
  } qpt_side_t;

endpackage

// ----- src/qpt_mult.sv -----
module qpt_mult #(
  parameter int FRAC_BITS = qpt_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                vld_in,
  input  logic signed [FRAC_BITS+1:0]         qw,
  input  logic signed [FRAC_BITS+1:0]         qx,
  input  logic signed [FRAC_BITS+1:0]         qy,
  input  logic signed [FRAC_BITS+1:0]         qz,
  output logic                                vld_r,
  output logic signed [2*FRAC_BITS+3:0]       prod_r [qpt_pkg::NUM_PROD]
);

  localparam int QW = FRAC_BITS + 2;
  localparam int PW = 2 * QW;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    prod_r[qpt_pkg::P_WW] <= PW'(qw * qw);
    prod_r[qpt_pkg::P_XX] <= PW'(qx * qx);
    prod_r[qpt_pkg::P_YY] <= PW'(qy * qy);
    prod_r[qpt_pkg::P_ZZ] <= PW'(qz * qz);
    prod_r[qpt_pkg::P_XY] <= PW'(qx * qy);
    prod_r[qpt_pkg::P_WZ] <= PW'(qw * qz);
    prod_r[qpt_pkg::P_XZ] <= PW'(qx * qz);
    prod_r[qpt_pkg::P_WY] <= PW'(qw * qy);
    prod_r[qpt_pkg::P_YZ] <= PW'(qy * qz);
    prod_r[qpt_pkg::P_WX] <= PW'(qw * qx);
  end

endmodule

// ----- src/qpt_numer.sv -----
module qpt_numer #(
  parameter int FRAC_BITS = qpt_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vld_in,
  input  logic signed [2*FRAC_BITS+3:0] prod [qpt_pkg::NUM_PROD],
  output logic                          vld_r,
  output logic [2*FRAC_BITS+4:0]        mag_r [qpt_pkg::NUM_ENT],
  output logic [2*FRAC_BITS+4:0]        norm_r,
  output qpt_pkg::qpt_side_t            side_r
);

  localparam int QW = FRAC_BITS + 2;
  localparam int NW = 2 * QW + 1;
  localparam int SW = NW + 1;

  logic signed [SW-1:0] e [qpt_pkg::NUM_PROD];
  logic signed [SW-1:0] num [qpt_pkg::NUM_ENT];
  logic signed [SW-1:0] nsum;
  logic signed [SW-1:0] neg_num [qpt_pkg::NUM_ENT];
  qpt_pkg::qpt_side_t   side_nxt;

  always_comb begin
    for (int i = 0; i < qpt_pkg::NUM_PROD; i++) begin
      e[i] = SW'(prod[i]);
    end
    nsum = e[qpt_pkg::P_WW] + e[qpt_pkg::P_XX] + e[qpt_pkg::P_YY] + e[qpt_pkg::P_ZZ];
    num[0] = e[qpt_pkg::P_WW] + e[qpt_pkg::P_XX] - e[qpt_pkg::P_YY] - e[qpt_pkg::P_ZZ];
    num[1] = (e[qpt_pkg::P_XY] - e[qpt_pkg::P_WZ]) <<< 1;
    num[2] = (e[qpt_pkg::P_XZ] + e[qpt_pkg::P_WY]) <<< 1;
    num[3] = (e[qpt_pkg::P_XY] + e[qpt_pkg::P_WZ]) <<< 1;
    num[4] = e[qpt_pkg::P_WW] - e[qpt_pkg::P_XX] + e[qpt_pkg::P_YY] - e[qpt_pkg::P_ZZ];
    num[5] = (e[qpt_pkg::P_YZ] - e[qpt_pkg::P_WX]) <<< 1;
    num[6] = (e[qpt_pkg::P_XZ] - e[qpt_pkg::P_WY]) <<< 1;
    num[7] = (e[qpt_pkg::P_YZ] + e[qpt_pkg::P_WX]) <<< 1;
    num[8] = e[qpt_pkg::P_WW] - e[qpt_pkg::P_XX] - e[qpt_pkg::P_YY] + e[qpt_pkg::P_ZZ];
    side_nxt.zero = (nsum == '0);
    for (int k = 0; k < qpt_pkg::NUM_ENT; k++) begin
      neg_num[k]      = -num[k];
      side_nxt.neg[k] = num[k][SW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    norm_r <= nsum[NW-1:0];
    side_r <= side_nxt;
    for (int k = 0; k < qpt_pkg::NUM_ENT; k++) begin
      mag_r[k] <= num[k][SW-1] ? neg_num[k][NW-1:0] : num[k][NW-1:0];
    end
  end

endmodule

// ----- src/qpt_div.sv -----
module qpt_div #(
  parameter int FRAC_BITS = qpt_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   vld_in,
  input  logic [2*FRAC_BITS+4:0] mag [qpt_pkg::NUM_ENT],
  input  logic [2*FRAC_BITS+4:0] norm,
  input  qpt_pkg::qpt_side_t     side_in,
  output logic                   vld_out,
  output logic [FRAC_BITS:0]     quo [qpt_pkg::NUM_ENT],
  output qpt_pkg::qpt_side_t     side_out
);

  localparam int QW    = FRAC_BITS + 2;
  localparam int NW    = 2 * QW + 1;
  localparam int AW    = NW + FRAC_BITS + 2;
  localparam int DEPTH = FRAC_BITS + 2;

  // restoring division, one quotient bit per stage, stage 0 builds dividend
  logic [AW-1:0]        rem_r  [DEPTH][qpt_pkg::NUM_ENT];
  logic [FRAC_BITS:0]   q_r    [DEPTH][qpt_pkg::NUM_ENT];
  logic [AW-1:0]        d2_r   [DEPTH];
  qpt_pkg::qpt_side_t   side_r [DEPTH];
  logic [DEPTH-1:0]     vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DEPTH-2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    d2_r[0]   <= AW'(norm) << 1;
    side_r[0] <= side_in;
    for (int k = 0; k < qpt_pkg::NUM_ENT; k++) begin
      rem_r[0][k] <= (AW'(mag[k]) << (FRAC_BITS + 1)) + AW'(norm);
      q_r[0][k]   <= '0;
    end
  end

  for (genvar s = 1; s < DEPTH; s++) begin : g_stage
    localparam int BIT = FRAC_BITS + 1 - s;
    logic [AW-1:0] cand;
    assign cand = d2_r[s-1] << BIT;

    always_ff @(posedge clk) begin
      d2_r[s]   <= d2_r[s-1];
      side_r[s] <= side_r[s-1];
      for (int k = 0; k < qpt_pkg::NUM_ENT; k++) begin
        if (rem_r[s-1][k] >= cand) begin
          rem_r[s][k] <= rem_r[s-1][k] - cand;
          q_r[s][k]   <= q_r[s-1][k] | ((FRAC_BITS+1)'(1) << BIT);
        end else begin
          rem_r[s][k] <= rem_r[s-1][k];
          q_r[s][k]   <= q_r[s-1][k];
        end
      end
    end
  end

  assign vld_out  = vld_r[DEPTH-1];
  assign side_out = side_r[DEPTH-1];
  always_comb begin
    for (int k = 0; k < qpt_pkg::NUM_ENT; k++) begin
      quo[k] = q_r[DEPTH-1][k];
    end
  end

endmodule

// ----- src/quaternion_pose_to_transform.sv -----
// path from start to out_valid: product, numerator, divider stage and output registers
// throughput: one pose per cycle, busy is never raised
// the depth is set by the restoring divider, one quotient bit per stage
// reset clears all valid bits, results are not held off by the receiver
module quaternion_pose_to_transform #(
  parameter int FRAC_BITS = qpt_pkg::FRAC_BITS_DEF,
  parameter int POS_WIDTH = qpt_pkg::POS_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [FRAC_BITS+1:0] in_quat_w,
  input  logic signed [FRAC_BITS+1:0] in_quat_x,
  input  logic signed [FRAC_BITS+1:0] in_quat_y,
  input  logic signed [FRAC_BITS+1:0] in_quat_z,
  input  logic signed [POS_WIDTH-1:0] in_pos_x,
  input  logic signed [POS_WIDTH-1:0] in_pos_y,
  input  logic signed [POS_WIDTH-1:0] in_pos_z,
  output logic                        out_valid,
  output logic signed [FRAC_BITS+1:0] out_rot_00,
  output logic signed [FRAC_BITS+1:0] out_rot_01,
  output logic signed [FRAC_BITS+1:0] out_rot_02,
  output logic signed [FRAC_BITS+1:0] out_rot_10,
  output logic signed [FRAC_BITS+1:0] out_rot_11,
  output logic signed [FRAC_BITS+1:0] out_rot_12,
  output logic signed [FRAC_BITS+1:0] out_rot_20,
  output logic signed [FRAC_BITS+1:0] out_rot_21,
  output logic signed [FRAC_BITS+1:0] out_rot_22,
  output logic signed [POS_WIDTH-1:0] out_x,
  output logic signed [POS_WIDTH-1:0] out_y,
  output logic signed [POS_WIDTH-1:0] out_z
);

  localparam int QW    = FRAC_BITS + 2;
  localparam int NW    = 2 * QW + 1;
  localparam int PDLY  = FRAC_BITS + 4;
  localparam int LAT   = FRAC_BITS + 5;
  localparam logic signed [QW-1:0] ONE = QW'(1) << FRAC_BITS;

  logic                      accept;
  logic                      m_vld;
  logic signed [2*QW-1:0]    m_prod [qpt_pkg::NUM_PROD];
  logic                      n_vld;
  logic [NW-1:0]             n_mag [qpt_pkg::NUM_ENT];
  logic [NW-1:0]             n_norm;
  qpt_pkg::qpt_side_t        n_side;
  logic                      d_vld;
  logic [FRAC_BITS:0]        d_quo [qpt_pkg::NUM_ENT];
  qpt_pkg::qpt_side_t        d_side;
  logic [3*POS_WIDTH-1:0]    pos_dly_r [PDLY];
  logic signed [QW-1:0]      rot_nxt [qpt_pkg::NUM_ENT];
  logic signed [QW-1:0]      rot_r [qpt_pkg::NUM_ENT];
  logic [3*POS_WIDTH-1:0]    pos_r;
  logic                      out_valid_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  qpt_mult #(.FRAC_BITS(FRAC_BITS)) u_mult (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_in (accept),
    .qw     (in_quat_w),
    .qx     (in_quat_x),
    .qy     (in_quat_y),
    .qz     (in_quat_z),
    .vld_r  (m_vld),
    .prod_r (m_prod)
  );

  qpt_numer #(.FRAC_BITS(FRAC_BITS)) u_numer (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_in (m_vld),
    .prod   (m_prod),
    .vld_r  (n_vld),
    .mag_r  (n_mag),
    .norm_r (n_norm),
    .side_r (n_side)
  );

  qpt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_in   (n_vld),
    .mag      (n_mag),
    .norm     (n_norm),
    .side_in  (n_side),
    .vld_out  (d_vld),
    .quo      (d_quo),
    .side_out (d_side)
  );

  // translation rides alongside the rotation pipeline
  always_ff @(posedge clk) begin
    pos_dly_r[0] <= {in_pos_x, in_pos_y, in_pos_z};
    for (int i = 1; i < PDLY; i++) begin
      pos_dly_r[i] <= pos_dly_r[i-1];
    end
  end

  always_comb begin
    for (int k = 0; k < qpt_pkg::NUM_ENT; k++) begin
      if (d_side.zero) begin
        rot_nxt[k] = (k % 4 == 0) ? ONE : '0;
      end else if (d_side.neg[k]) begin
        rot_nxt[k] = -QW'(d_quo[k]);
      end else begin
        rot_nxt[k] = QW'(d_quo[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    rot_r <= rot_nxt;
    pos_r <= pos_dly_r[PDLY-1];
  end

  assign out_valid  = out_valid_r;
  assign out_rot_00 = rot_r[0];
  assign out_rot_01 = rot_r[1];
  assign out_rot_02 = rot_r[2];
  assign out_rot_10 = rot_r[3];
  assign out_rot_11 = rot_r[4];
  assign out_rot_12 = rot_r[5];
  assign out_rot_20 = rot_r[6];
  assign out_rot_21 = rot_r[7];
  assign out_rot_22 = rot_r[8];
  assign out_x      = pos_r[3*POS_WIDTH-1:2*POS_WIDTH];
  assign out_y      = pos_r[2*POS_WIDTH-1:POS_WIDTH];
  assign out_z      = pos_r[POS_WIDTH-1:0];

  a_lat_hit: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##(LAT) out_valid)
    else $error("transfer did not reach the output on time");

  a_lat_miss: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |-> ##(LAT) !out_valid)
    else $error("result without a matching transfer");

  a_diag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rot_00 <= ONE) && (out_rot_00 >= -ONE)
                  && (out_rot_11 <= ONE) && (out_rot_11 >= -ONE))
    else $error("diagonal entry out of range");

  a_zero_ident: assert property (@(posedge clk) disable iff (!rst_n)
    d_vld && d_side.zero |=> (out_rot_00 == ONE) && (out_rot_01 == '0)
                            && (out_rot_22 == ONE))
    else $error("zero quaternion did not give identity");

endmodule
